// ===== src/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, payload types, cell data types and the output saturation.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// Field widths
	localparam int CW     = 16;                  // coefficient width
	localparam int FRAC   = 16;                  // Q16 scaling of the roots
	localparam int OUT_W  = 48;                  // result part width
	localparam int KIND_W = 3;

	// Derived datapath widths
	localparam int DSW = 2 * CW + 3;             // signed discriminant
	localparam int DW  = 2 * CW + 1;             // discriminant magnitude
	localparam int RW  = (DW + 2 * FRAC + 1) / 2; // square root bits
	localparam int SQW = 2 * RW;                 // radicand bits
	localparam int NBW = CW + FRAC + 1;          // signed base numerator
	localparam int NW  = RW + 1;                 // numerator magnitude
	localparam int SW  = NW + 1;                 // signed numerator
	localparam int DVW = CW + 1;                 // divisor magnitude

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [KIND_W-1:0] {
		KIND_ZERO    = 3'd0,
		KIND_NOT_EQ  = 3'd1,
		KIND_SINGLE  = 3'd2,
		KIND_REAL    = 3'd3,
		KIND_COMPLEX = 3'd4
	} kind_t;

	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
	} in_t;

	typedef struct packed {
		kind_t                   kind;
		logic signed [OUT_W-1:0] real_part;
		logic signed [OUT_W-1:0] imag_part;
		logic                    last;
	} out_t;

	// Per-item information that rides along the cell chains.
	typedef struct packed {
		kind_t                 kind;
		logic                  a_neg;
		logic                  dneg;
		logic [1:0]            nneg;
		logic signed [NBW-1:0] nbase;
		logic [DVW-1:0]        dmag;
	} side_t;

	// Square root cell data.
	typedef struct packed {
		logic [SQW-1:0] rad;
		logic [RW+1:0]  rem;
		logic [RW-1:0]  root;
	} sqrt_t;

	// Divider cell data, two lanes.
	typedef struct packed {
		logic [1:0][NW-1:0]  num;
		logic [1:0][DVW-1:0] rem;
		logic [1:0][NW-1:0]  quo;
	} div_t;

	// Clamp a signed quotient to the result range.
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX;
		end else if (v < OUT_MIN) begin
			r = OUT_MIN;
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== src/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of a restoring square root; registered toward the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  qrs_pkg::sqrt_t d_in,
	input  qrs_pkg::side_t s_in,
	output logic          v_out,
	output qrs_pkg::sqrt_t d_out,
	output qrs_pkg::side_t s_out
);
	import qrs_pkg::*;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fit;
	sqrt_t         nxt;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		rem_sh   = {d_in.rem[RW-1:0], d_in.rad[SQW-1 -: 2]};
		trial    = {d_in.root, 2'b01};
		fit      = (rem_sh >= trial);
		nxt.rem  = fit ? (rem_sh - trial) : rem_sh;
		nxt.root = {d_in.root[RW-2:0], fit};
		nxt.rad  = {d_in.rad[SQW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out <= nxt;
		s_out <= s_in;
	end

endmodule

// ===== src/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of two restoring divisions that share one divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  qrs_pkg::div_t  d_in,
	input  qrs_pkg::side_t s_in,
	output logic          v_out,
	output qrs_pkg::div_t  d_out,
	output qrs_pkg::side_t s_out
);
	import qrs_pkg::*;

	logic [DVW:0] rem_sh;
	logic [DVW:0] dv;
	logic         fit;
	div_t         nxt;

	// Shift in the next numerator bit per lane and subtract where it fits.
	always_comb begin
		dv  = {1'b0, s_in.dmag};
		nxt = d_in;
		for (int l = 0; l < 2; l++) begin
			rem_sh     = {d_in.rem[l], d_in.num[l][NW-1]};
			fit        = (rem_sh >= dv);
			nxt.rem[l] = DVW'(fit ? (rem_sh - dv) : rem_sh);
			nxt.quo[l] = {d_in.quo[l][NW-2:0], fit};
			nxt.num[l] = {d_in.num[l][NW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out <= nxt;
		s_out <= s_in;
	end

endmodule

// ===== src/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver: front-end registers, square root cells, numerator
// register, divider cells, result register; a second result follows in the
// next cycle. A new item waits only while busy. Reset clears all valid bits
// and busy; the receiver cannot stall.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  qrs_pkg::in_t   operands,
	output logic          done,
	output qrs_pkg::out_t  result
);
	import qrs_pkg::*;

	logic accept;
	logic busy_q;

	// Stage registers of the front end
	logic                   v_s1, v_s2, v_s3, v_s4;
	in_t                    op_s1;
	logic signed [CW-1:0]   a_s2, b_s2, c_s2;
	logic signed [2*CW-1:0] bb_s2, ac_s2;
	sqrt_t                  sq_s3;
	side_t                  side_s3;
	div_t                   dv_s4;
	side_t                  side_s4;

	// Cell chains
	logic  [RW:0] sq_v;
	sqrt_t        sq_d [RW+1];
	side_t        sq_s [RW+1];
	logic  [NW:0] dc_v;
	div_t         dc_d [NW+1];
	side_t        dc_s [NW+1];

	// Output registers
	logic done_q, pend_q;
	out_t res_q, pend_res_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;

	// Busy for one cycle after each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	// Front end valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_v[RW];
		end
	end

	// Input capture and products.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= operands;
		end
		a_s2  <= op_s1.coef_a;
		b_s2  <= op_s1.coef_b;
		c_s2  <= op_s1.coef_c;
		bb_s2 <= op_s1.coef_b * op_s1.coef_b;
		ac_s2 <= op_s1.coef_a * op_s1.coef_c;
	end

	// Discriminant, classification and divider setup.
	logic signed [DSW-1:0] disc;
	logic [DW-1:0]         dabs;
	logic signed [DVW:0]   a2, bx;
	side_t                 side_n;

	always_comb begin
		disc = DSW'(bb_s2) - (DSW'(ac_s2) <<< 2);
		dabs = DW'(disc[DSW-1] ? -disc : disc);
		a2   = (DVW+1)'(a_s2) <<< 1;
		bx   = (DVW+1)'(b_s2);
		side_n.a_neg = a_s2[CW-1];
		side_n.nneg  = 2'b00;
		if (a_s2 == '0) begin
			side_n.nbase = -(NBW'(c_s2) <<< FRAC);
			side_n.dmag  = DVW'(bx[DVW] ? -bx : bx);
			side_n.dneg  = b_s2[CW-1];
			if (b_s2 != '0) begin
				side_n.kind = KIND_SINGLE;
			end else if (c_s2 != '0) begin
				side_n.kind = KIND_NOT_EQ;
			end else begin
				side_n.kind = KIND_ZERO;
			end
		end else begin
			side_n.nbase = -(NBW'(b_s2) <<< FRAC);
			side_n.dmag  = DVW'(a2[DVW] ? -a2 : a2);
			side_n.dneg  = a_s2[CW-1];
			if (disc == '0) begin
				side_n.kind = KIND_SINGLE;
			end else if (disc[DSW-1]) begin
				side_n.kind = KIND_COMPLEX;
			end else begin
				side_n.kind = KIND_REAL;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s3.rad  <= SQW'({dabs, {(2*FRAC){1'b0}}});
		sq_s3.rem  <= '0;
		sq_s3.root <= '0;
		side_s3    <= side_n;
	end

	// Square root chain, one root bit per cell.
	assign sq_v[0] = v_s3;
	assign sq_d[0] = sq_s3;
	assign sq_s[0] = side_s3;

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.v_in  (sq_v[i]),
			.d_in  (sq_d[i]),
			.s_in  (sq_s[i]),
			.v_out (sq_v[i+1]),
			.d_out (sq_d[i+1]),
			.s_out (sq_s[i+1])
		);
	end

	// Numerators for the two division lanes.
	logic signed [SW-1:0] nb, rr, n1, n2;
	side_t                side_p;
	div_t                 div_n;

	always_comb begin
		nb     = SW'(sq_s[RW].nbase);
		rr     = SW'({1'b0, sq_d[RW].root});
		side_p = sq_s[RW];
		case (sq_s[RW].kind)
			KIND_REAL: begin
				n1 = nb + rr;
				n2 = nb - rr;
			end
			KIND_COMPLEX: begin
				n1 = nb;
				n2 = rr;
			end
			KIND_SINGLE: begin
				n1 = nb;
				n2 = '0;
			end
			default: begin
				n1 = '0;
				n2 = '0;
			end
		endcase
		side_p.nneg   = {n2[SW-1], n1[SW-1]};
		div_n.num[0]  = NW'(n1[SW-1] ? -n1 : n1);
		div_n.num[1]  = NW'(n2[SW-1] ? -n2 : n2);
		div_n.rem     = '0;
		div_n.quo     = '0;
	end

	always_ff @(posedge clk) begin
		dv_s4   <= div_n;
		side_s4 <= side_p;
	end

	// Divider chain, one quotient bit per cell.
	assign dc_v[0] = v_s4;
	assign dc_d[0] = dv_s4;
	assign dc_s[0] = side_s4;

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.v_in  (dc_v[j]),
			.d_in  (dc_d[j]),
			.s_in  (dc_s[j]),
			.v_out (dc_v[j+1]),
			.d_out (dc_d[j+1]),
			.s_out (dc_s[j+1])
		);
	end

	// Signs, saturation, root order and the two result items.
	side_t                   fs;
	logic signed [SW-1:0]    q1, q2;
	logic signed [OUT_W-1:0] x1, x2;
	out_t                    r0, r1;

	always_comb begin
		fs = dc_s[NW];
		q1 = SW'(dc_d[NW].quo[0]);
		q2 = SW'(dc_d[NW].quo[1]);
		if (fs.nneg[0] ^ fs.dneg) begin
			q1 = -q1;
		end
		if ((fs.kind != KIND_COMPLEX) && (fs.nneg[1] ^ fs.dneg)) begin
			q2 = -q2;
		end
		x1 = sat_out(q1);
		x2 = sat_out(q2);
		r0.kind      = fs.kind;
		r0.real_part = '0;
		r0.imag_part = '0;
		r0.last      = 1'b1;
		r1           = r0;
		case (fs.kind)
			KIND_SINGLE: begin
				r0.real_part = x1;
			end
			KIND_REAL: begin
				r0.last      = 1'b0;
				r0.real_part = fs.a_neg ? x2 : x1;
				r1.real_part = fs.a_neg ? x1 : x2;
			end
			KIND_COMPLEX: begin
				r0.last      = 1'b0;
				r0.real_part = x1;
				r0.imag_part = x2;
				r1.real_part = x1;
				r1.imag_part = -x2;
			end
			default: begin
				r0.real_part = '0;
			end
		endcase
	end

	// Result port: first item at once, the second in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (dc_v[NW]) begin
			done_q <= 1'b1;
			pend_q <= !r0.last;
		end else begin
			done_q <= pend_q;
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dc_v[NW]) begin
			res_q      <= r0;
			pend_res_q <= r1;
		end else if (pend_q) begin
			res_q <= pend_res_q;
		end
	end

`ifndef NO_ASSERTIONS
	// An accepted item blocks the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	// Busy always falls at once after it is raised.
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for two cycles");

	// A result that is not the last is followed at once by the last one.
	a_second_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |=> done && result.last)
		else $error("second result of an item missing");

	// A new item never leaves the divider while a second result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !dc_v[NW])
		else $error("result items overlap");
`endif

endmodule
